// ===== rtl/tdpc_pkg.sv =====
package tdpc_pkg;

    // Width of the candidate and of the running prime count
    localparam int VALUE_BITS = 20;

    typedef struct packed {
        logic [VALUE_BITS-1:0] candidate;
        logic                  restart;
    } t_in_item;

    typedef struct packed {
        logic                  is_prime;
        logic [VALUE_BITS-1:0] prime_count;
    } t_out_item;

    // Status of the serial remainder unit toward the sequencer
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder is final
        logic zero;   // remainder equals zero, valid with done
    } t_rem_status;

endpackage

// ===== rtl/tdpc_rem.sv =====
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
module tdpc_rem #(
    parameter int P_WIDTH = tdpc_pkg::VALUE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [P_WIDTH-1:0]     i_dividend,
    input  logic [P_WIDTH-1:0]     i_divisor,
    output tdpc_pkg::t_rem_status  o_status
);

    localparam int CW = $clog2(P_WIDTH + 1);

    logic [P_WIDTH-1:0] r_rem,   n_rem;
    logic [P_WIDTH-1:0] r_shift, n_shift;
    logic [CW-1:0]      r_cnt,   n_cnt;
    logic               r_busy,  n_busy;
    logic               r_done,  n_done;

    logic [P_WIDTH:0]   w_trial;
    logic [P_WIDTH:0]   w_diff;

    // Bring in the next dividend bit and subtract when the divisor fits
    assign w_trial = {r_rem, r_shift[P_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_comb begin
        n_rem   = r_rem;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem   = '0;
            n_shift = i_dividend;
            n_cnt   = CW'(P_WIDTH);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = w_diff[P_WIDTH-1:0];
            end else begin
                n_rem = w_trial[P_WIDTH-1:0];
            end
            n_shift = {r_shift[P_WIDTH-2:0], 1'b0};
            n_cnt   = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem   <= n_rem;
        r_shift <= n_shift;
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

endmodule

// ===== rtl/trial_division_prime_counter_core.sv =====
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+---------------------------------
// in      | input     | i_in_valid / o_in_stall    | i_in_data  (candidate, restart)
// out     | output    | o_out_valid / i_out_stall  | o_out_data (is_prime, prime_count)
//
// One item is processed at a time. Each trial divisor takes a square bound check, then a
// bit-serial remainder in the remainder unit; a prime near 2^20 runs about 1022 divisors.
// Reset (synchronous, active low) clears the running count and the sequencer.
// A finished result waits in the output register while the next item is accepted;
// the sequencer holds in its finish state only if that register is still full.
module trial_division_prime_counter_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tdpc_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tdpc_pkg::t_out_item   o_out_data
);

    localparam int W  = tdpc_pkg::VALUE_BITS;
    localparam int SW = W + 2;   // headroom for divisor squared past the candidate

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [W-1:0]        r_cand;
    logic                r_restart;
    logic [W-1:0]        r_div;
    logic [SW-1:0]       r_sq;
    logic                r_prime;
    logic [W-1:0]        r_count;
    logic                r_out_valid;
    tdpc_pkg::t_out_item r_out;

    logic                  w_accept;
    logic                  w_start;
    logic                  w_load;
    logic [W-1:0]          w_base;
    logic [W-1:0]          w_count_next;
    tdpc_pkg::t_rem_status w_rem;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Launch a remainder once the bound still admits the current divisor
    assign w_start = (r_state == S_CHECK) && (r_cand >= W'(2)) && (r_sq <= SW'(r_cand));

    // Retire the item when the output register is free or being emptied
    assign w_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Clear first on restart, then count the prime, saturating at all ones
    assign w_base       = r_restart ? '0 : r_count;
    assign w_count_next = (r_prime && (w_base != '1)) ? w_base + W'(1) : w_base;

    tdpc_rem #(
        .P_WIDTH (W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_status   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one replaces it now
            if (r_out_valid && !i_out_stall && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_cand < W'(2)) begin
                        r_prime <= 1'b0;
                        r_state <= S_DONE;
                    end else if (w_start) begin
                        r_state <= S_DIV;
                    end else begin
                        // divisor squared passed the candidate: no factor found
                        r_prime <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (w_rem.done) begin
                        if (w_rem.zero) begin
                            r_prime <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            // advance: (d+1)^2 = d^2 + 2d + 1
                            r_div   <= r_div + W'(1);
                            r_sq    <= r_sq + SW'({r_div, 1'b1});
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_count     <= w_count_next;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        // Payload registers
        if (w_accept) begin
            r_cand    <= i_in_data.candidate;
            r_restart <= i_in_data.restart;
            r_div     <= W'(2);
            r_sq      <= SW'(4);
        end
        if (w_load) begin
            r_out.is_prime    <= r_prime;
            r_out.prime_count <= w_count_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A prime item always leaves a nonzero count behind it
    a_prime_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_prime) |=> (o_out_data.prime_count != '0))
        else $error("prime retired with zero count");

    // Candidates below two are never reported prime
    a_small_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_prime) |-> (r_cand >= W'(2)))
        else $error("candidate below two reported prime");

    // The remainder unit only finishes while the sequencer waits for it
    a_rem_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem.done |-> (r_state == S_DIV))
        else $error("remainder done outside divide state");

    // Trial divisors start at two
    a_div_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div >= W'(2)))
        else $error("trial divisor below two");

endmodule

// ===== dv/prime_count_checker.sv =====
`timescale 1ns / 100ps

module prime_count_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  tdpc_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  tdpc_pkg::t_out_item i_out_data,
    output int                  o_mismatches,
    output int                  o_outstanding,
    output int                  o_primes_seen
);
    import tdpc_pkg::*;

    localparam logic [VALUE_BITS-1:0] COUNT_MAX    = '1;
    localparam int                    REPORT_LIMIT = 10;

    logic [VALUE_BITS-1:0] prime_tally;
    t_out_item             expected_q[$];
    int                    mismatch_total;
    int                    primes_total;

    // Trial division: stop at the first exact divisor, bound d*d <= n
    function automatic logic trial_divide(logic [VALUE_BITS-1:0] value);
        longint unsigned n;
        longint unsigned d;
        n = value;
        if (n < 2) begin
            return 1'b0;
        end
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out_item predicted;
        t_out_item oldest;
        logic      prime;
        if (!i_rst_n) begin
            prime_tally    = '0;
            mismatch_total = 0;
            primes_total   = 0;
            expected_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                prime = trial_divide(i_in_data.candidate);
                // clear first, then count, saturating at the top
                if (i_in_data.restart) begin
                    prime_tally = '0;
                end
                if (prime && prime_tally != COUNT_MAX) begin
                    prime_tally = prime_tally + 1'b1;
                end
                if (prime) begin
                    primes_total++;
                end
                predicted.is_prime    = prime;
                predicted.prime_count = prime_tally;
                expected_q.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    if (mismatch_total < REPORT_LIMIT) begin
                        $display("unexpected result: is_prime=%0b prime_count=%0d",
                                 i_out_data.is_prime, i_out_data.prime_count);
                    end
                    mismatch_total++;
                end else begin
                    oldest = expected_q.pop_front();
                    if (oldest.is_prime !== i_out_data.is_prime ||
                        oldest.prime_count !== i_out_data.prime_count) begin
                        if (mismatch_total < REPORT_LIMIT) begin
                            $display("result mismatch: expected is_prime=%0b prime_count=%0d, %s",
                                     oldest.is_prime, oldest.prime_count,
                                     $sformatf("got is_prime=%0b prime_count=%0d",
                                               i_out_data.is_prime, i_out_data.prime_count));
                        end
                        mismatch_total++;
                    end
                end
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= expected_q.size();
        o_primes_seen <= primes_total;
    end

endmodule

// ===== dv/tb_trial_division_prime_counter_core.sv =====
`timescale 1ns / 100ps

module tb_trial_division_prime_counter_core;
    import tdpc_pkg::*;

    // The worst case per item is the largest prime; the run mixes a few of those with
    // many small candidates.
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int HOLD_CYCLES  = 4000;
    localparam int RANDOM_ITEMS = 100;
    localparam int WARMUP_ITEMS = 8;
    // After the last result nothing is in flight; allow a couple of divisor steps
    localparam int DRAIN_CYCLES = 2 * (VALUE_BITS + 2) + 16;

    localparam logic [VALUE_BITS-1:0] ALL_ONES       = '1;
    localparam logic [VALUE_BITS-1:0] LARGEST_PRIME  = ALL_ONES - 2'd2;
    localparam logic [VALUE_BITS-1:0] PRIME_SQUARE   = VALUE_BITS'(1021 * 1021);
    localparam logic [VALUE_BITS-1:0] MERSENNE_PRIME = VALUE_BITS'(524287);

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    logic      in_stall;
    t_in_item  in_data    = '0;
    logic      out_valid;
    logic      out_stall  = 1'b0;
    t_out_item out_data;

    int        mismatches;
    int        outstanding;
    int        primes_seen;
    int        cycle_count    = 0;
    int        items_sent     = 0;
    int        restarts_sent  = 0;
    logic      hold_request   = 1'b0;

    logic [VALUE_BITS-1:0] last_candidate = '0;

    trial_division_prime_counter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    prime_count_checker u_prime_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_primes_seen (primes_seen)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Abort the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("tb_trial_division_prime_counter_core failed");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long
    function automatic int idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return 0;
        end
        if (pick < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 150);
    endfunction

    // Receiver: alternate ready runs and stall runs; once, on request from the
    // sender, hold off for a long stretch so the block backs up into its input.
    initial begin : receiver
        logic held;
        int   run;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request && !held) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else begin
                out_stall <= 1'b0;
                // sometimes a long stretch with no stall at all
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
                repeat (run) @(posedge i_clk);
                run = idle_length();
                if (run > 0) begin
                    out_stall <= 1'b1;
                    repeat (run) @(posedge i_clk);
                end
            end
        end
    end

    // Offer one item after an optional gap; return at the edge that accepts it
    task automatic offer(input logic [VALUE_BITS-1:0] candidate, input logic restart);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid          <= 1'b1;
        in_data.candidate <= candidate;
        in_data.restart   <= restart;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
        if (restart) begin
            restarts_sent++;
        end
        last_candidate = candidate;
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (outstanding != 0);
    endtask

    initial begin : stimulus
        logic [VALUE_BITS-1:0] candidate;
        logic                  restart;
        int unsigned           pick;
        int                    sweep_left;
        sweep_left = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: below two, smallest primes, squares of primes at the divisor
        // bound, restart with and without a prime, and the field extremes.
        offer('0, 1'b1);
        offer(VALUE_BITS'(1), 1'b0);
        offer(VALUE_BITS'(2), 1'b0);
        offer(VALUE_BITS'(3), 1'b0);
        offer(VALUE_BITS'(4), 1'b0);
        offer(VALUE_BITS'(9), 1'b0);
        offer(VALUE_BITS'(25), 1'b0);
        offer(VALUE_BITS'(49), 1'b0);
        offer(VALUE_BITS'(97), 1'b0);
        offer(VALUE_BITS'(2), 1'b1);
        offer(VALUE_BITS'(5), 1'b0);
        offer('0, 1'b1);
        offer(VALUE_BITS'(1), 1'b1);
        offer(VALUE_BITS'(7), 1'b0);
        offer(ALL_ONES, 1'b0);
        offer(LARGEST_PRIME, 1'b0);
        offer(PRIME_SQUARE, 1'b0);
        offer(MERSENNE_PRIME, 1'b1);
        offer(VALUE_BITS'(65536), 1'b0);
        offer(VALUE_BITS'(65537), 1'b0);
        offer(LARGEST_PRIME, 1'b1);

        // Pause the sender until the block is empty
        wait_drained();

        // Ask for the long hold-off; the first items are tiny so the block fills
        hold_request = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            restart = ($urandom_range(0, 11) == 0);
            if (sweep_left > 0) begin
                // advance a counting sweep over consecutive candidates
                candidate = last_candidate + 1'b1;
                sweep_left--;
            end else if (n < WARMUP_ITEMS) begin
                candidate = VALUE_BITS'($urandom_range(0, 255));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    sweep_left = $urandom_range(4, 12);
                    candidate  = VALUE_BITS'($urandom_range(0, 63));
                    restart    = 1'b1;
                end else if (pick < 70) begin
                    candidate = VALUE_BITS'($urandom_range(0, 4095));
                end else if (pick < 92) begin
                    candidate = VALUE_BITS'($urandom_range(0, 65535));
                end else begin
                    candidate = VALUE_BITS'($urandom());
                end
            end
            offer(candidate, restart);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Sent %0d candidates (%0d with restart), %0d found prime.",
                 items_sent, restarts_sent, primes_seen);
        $display("Receiver held off %0d cycles once; run took %0d cycles.",
                 HOLD_CYCLES, cycle_count);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_trial_division_prime_counter_core passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, outstanding);
            $display("tb_trial_division_prime_counter_core failed");
        end
        $finish;
    end

endmodule
